[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank package
// Widths, register map, controller types and the factorial tables.
// ---------------------------------------------------------------------------
package pu_pkg;

    localparam int DEF_MAX_SYMBOLS = 8;
    localparam int RANK_W  = 16;
    localparam int SYM_W   = 8;
    localparam int POS_W   = 3;
    localparam int LIST_W  = 64;
    localparam int COUNT_W = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;

    localparam logic [LIST_W-1:0]  LIST_RESET  = 64'h3837363534333231;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic {
        REG_SYMBOL_LIST  = 1'b0,
        REG_SYMBOL_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic final_step;
    } t_status;

    // Entry [m][k] holds k * m!, for m and k up to seven.
    typedef logic [7:0][7:0][RANK_W-1:0] t_mult_tab;
    // Entry [m] holds m!, for m up to eight.
    typedef logic [8:0][RANK_W-1:0] t_fact_tab;

    function automatic t_mult_tab build_mult_tab();
        t_mult_tab tab;
        int        f;
        tab = '0;
        for (int m = 0; m < 8; m++) begin
            f = 1;
            for (int i = 2; i <= m; i++) begin
                f = f * i;
            end
            for (int k = 0; k < 8; k++) begin
                tab[m][k] = RANK_W'(k * f);
            end
        end
        return tab;
    endfunction

    function automatic t_fact_tab build_fact_tab();
        t_fact_tab tab;
        int        f;
        tab    = '0;
        f      = 1;
        tab[0] = RANK_W'(1);
        for (int i = 1; i <= 8; i++) begin
            f      = f * i;
            tab[i] = RANK_W'(f);
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT_TAB = build_mult_tab();
    localparam t_fact_tab FACT_TAB = build_fact_tab();

endpackage

[hdl/pu_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank controller
// Sequences one rank at a time and owns the valid bit of the result register.
// ---------------------------------------------------------------------------
module pu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pu_pkg::t_status i_status,
    output pu_pkg::t_cmd    o_cmd
);
    import pu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The result register may be refilled when it is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.final_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/pu_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank datapath
// Holds the working symbol list and rank, selects one symbol per step.
// ---------------------------------------------------------------------------
module pu_dpath #(
    parameter int MAX_SYMBOLS = pu_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pu_pkg::RANK_W-1:0]  i_rank,
    input  logic [pu_pkg::LIST_W-1:0]  i_symbol_list,
    input  logic [pu_pkg::COUNT_W-1:0] i_symbol_count,
    input  pu_pkg::t_cmd               i_cmd,
    output pu_pkg::t_status            o_status,
    output logic [pu_pkg::SYM_W-1:0]   o_symbol,
    output logic [pu_pkg::POS_W-1:0]   o_position,
    output logic                       o_last,
    output logic                       o_rank_error
);
    import pu_pkg::*;

    localparam int REM_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int LANE_W = $clog2(MAX_SYMBOLS);

    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] n_rank;
    logic [SYM_W-1:0]  r_work [MAX_SYMBOLS];
    logic [SYM_W-1:0]  n_work [MAX_SYMBOLS];
    logic [SYM_W-1:0]  up_work [MAX_SYMBOLS];
    logic [REM_W-1:0]  r_remaining;
    logic [REM_W-1:0]  n_remaining;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              r_err;
    logic              n_err;

    logic [SYM_W-1:0]  r_symbol;
    logic [POS_W-1:0]  r_position;
    logic              r_last;
    logic              r_rank_error;

    logic [REM_W-1:0]  eff_count;
    logic [REM_W-1:0]  rem_m1;
    logic [2:0]        row;
    logic [LANE_W-1:0] idx;
    logic [RANK_W-1:0] sub;

    // A count of zero behaves as one; above capacity it is clamped.
    always_comb begin
        if (i_symbol_count == '0) begin
            eff_count = REM_W'(1);
        end else if (int'(i_symbol_count) > MAX_SYMBOLS) begin
            eff_count = REM_W'(MAX_SYMBOLS);
        end else begin
            eff_count = REM_W'(i_symbol_count);
        end
    end

    // The quotient rank / (remaining-1)! is found by comparing the rank with
    // every multiple of the factorial at once; the multiples come from a table.
    always_comb begin
        rem_m1 = r_remaining - REM_W'(1);
        row    = 3'(rem_m1);
        idx    = '0;
        for (int k = 1; k < MAX_SYMBOLS; k++) begin
            if ((REM_W'(k) < r_remaining) && (r_rank >= MULT_TAB[row][k])) begin
                idx = LANE_W'(k);
            end
        end
        sub = MULT_TAB[row][3'(idx)];
    end

    for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_lane
        if (g < MAX_SYMBOLS - 1) begin : g_shift
            assign up_work[g] = r_work[g + 1];
        end else begin : g_top
            assign up_work[g] = r_work[g];
        end
    end

    always_comb begin
        n_rank      = r_rank;
        n_work      = r_work;
        n_remaining = r_remaining;
        n_pos       = r_pos;
        n_err       = r_err;
        if (i_cmd.load) begin
            n_rank      = i_rank;
            n_remaining = eff_count;
            n_pos       = '0;
            n_err       = (i_rank >= FACT_TAB[4'(eff_count)]);
            for (int l = 0; l < MAX_SYMBOLS; l++) begin
                n_work[l] = i_symbol_list[SYM_W*l +: SYM_W];
            end
        end else if (i_cmd.step && !r_err) begin
            n_rank      = r_rank - sub;
            n_remaining = rem_m1;
            n_pos       = r_pos + POS_W'(1);
            // The chosen symbol leaves the list; those above it move down.
            for (int l = 0; l < MAX_SYMBOLS; l++) begin
                if (LANE_W'(l) >= idx) begin
                    n_work[l] = up_work[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_pos       <= '0;
            r_err       <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_pos       <= n_pos;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
        r_work <= n_work;
        if (i_cmd.step) begin
            if (r_err) begin
                r_symbol     <= '0;
                r_position   <= '0;
                r_last       <= 1'b1;
                r_rank_error <= 1'b1;
            end else begin
                r_symbol     <= r_work[idx];
                r_position   <= r_pos;
                r_last       <= (r_remaining == REM_W'(1));
                r_rank_error <= 1'b0;
            end
        end
    end

    assign o_status.final_step = r_err || (r_remaining == REM_W'(1));
    assign o_symbol            = r_symbol;
    assign o_position          = r_position;
    assign o_last              = r_last;
    assign o_rank_error        = r_rank_error;

endmodule

[hdl/permutation_unrank_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank top level
// Lexicographic unranking over a configurable list of byte symbols.
// ---------------------------------------------------------------------------
// A rank is taken only while the block is idle. It then gives one result per
// position, one per cycle while the downstream side keeps accepting, with the
// last flag on the final one; a rank of at least n! gives a single result with
// both the error and last flags set. Each rank is first loaded, then each
// position comes from the single select-and-remove step, which produces one
// symbol a cycle while the result register is free. The next rank may be taken
// as soon as the final result sits in the output register. Registers sit at
// byte addresses 0 (symbol list) and 8 (symbol count) and may only be written
// while no rank is in progress.
module permutation_unrank_top #(
    parameter int MAX_SYMBOLS = pu_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [pu_pkg::RANK_W-1:0] i_rank,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [pu_pkg::SYM_W-1:0]  o_symbol,
    output logic [pu_pkg::POS_W-1:0]  o_position,
    output logic                      o_last,
    output logic                      o_rank_error,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pu_pkg::ADDR_W-1:0] paddr,
    input  logic [pu_pkg::DATA_W-1:0] pwdata,
    output logic [pu_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import pu_pkg::*;

    logic [LIST_W-1:0]  r_symbol_list;
    logic [COUNT_W-1:0] r_symbol_count;
    logic               wr_en;
    t_reg_idx           reg_idx;
    t_cmd               cmd;
    t_status            status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_list  <= LIST_RESET;
            r_symbol_count <= COUNT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYMBOL_LIST:  r_symbol_list  <= pwdata[LIST_W-1:0];
                REG_SYMBOL_COUNT: r_symbol_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYMBOL_LIST:  prdata = DATA_W'(r_symbol_list);
            REG_SYMBOL_COUNT: prdata = DATA_W'(r_symbol_count);
            default:          prdata = '0;
        endcase
    end

    pu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pu_dpath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rank         (i_rank),
        .i_symbol_list  (r_symbol_list),
        .i_symbol_count (r_symbol_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_symbol       (o_symbol),
        .o_position     (o_position),
        .o_last         (o_last),
        .o_rank_error   (o_rank_error)
    );

endmodule

[hdl/pu_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank checker
// Port-level assertions on the result sequence, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pu_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [pu_pkg::SYM_W-1:0]  o_symbol,
    input logic [pu_pkg::POS_W-1:0]  o_position,
    input logic                      o_last,
    input logic                      o_rank_error
);

    // An out-of-range rank yields one blank result that ends the sequence.
    `ASSERT_IMPLY(a_err_result, i_clk, i_rst_n, o_valid && o_rank_error, o_last && (o_symbol == '0) && (o_position == '0), "error result is not a blank final result")

    // Once a rank is taken the block is not ready again in the next cycle.
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input ready straight after a transfer")

    // While a rank is only partly delivered, no new rank may be taken.
    `ASSERT_IMPLY(a_no_take_mid_rank, i_clk, i_rst_n, o_valid && !o_last, !o_ready, "input ready while a rank is incomplete")

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_symbol) && $stable(o_position) && $stable(o_last), "stalled result changed")

endmodule

bind permutation_unrank_top pu_checker u_pu_checker (.*);
